@@ sv/lcdfb_pkg.sv @@
package lcdfb_pkg;

  // Fixed field widths of the stream items
  localparam int OP_W     = 2;
  localparam int PAGE_W   = 2;
  localparam int COL_IN_W = 6;
  localparam int BYTE_W   = 8;
  localparam int ROW_W    = 5;
  localparam int IDX_W    = 4;
  localparam int LANES    = 8;   // columns held in one memory word
  localparam int IN_W     = OP_W + 1 + PAGE_W + COL_IN_W + BYTE_W + ROW_W;
  localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((BYTE_W + IDX_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_LOCATE   = 2'd0,
    OP_WRITE    = 2'd1,
    OP_READ_ROW = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ
  } state_e;

  typedef struct packed {
    logic clear_step;
    logic accept;
    logic read_start;
    logic read_issue;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic read_last;
    logic out_space;
  } dp_status_t;

endpackage

@@ sv/lcdfb_ctrl.sv @@
module lcdfb_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic [lcdfb_pkg::OP_W-1:0] in_op_i,
  output logic                   in_ready_o,
  input  lcdfb_pkg::dp_status_t  status_i,
  output lcdfb_pkg::ctrl_cmd_t   cmd_o
);
  import lcdfb_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (status_i.clear_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && (op_e'(in_op_i) == OP_READ_ROW)) begin
          cmd_o.read_start = 1'b1;
          state_d          = ST_READ;
        end
      end
      ST_READ: begin
        // Issue one word read per output byte while the output queue has room
        cmd_o.read_issue = status_i.out_space;
        if (status_i.out_space && status_i.read_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ sv/lcdfb_dp.sv @@
module lcdfb_dp #(
  parameter int COLUMNS_PER_SIDE = 61,
  parameter int PAGES            = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lcdfb_pkg::ctrl_cmd_t          cmd_i,
  output lcdfb_pkg::dp_status_t         status_o,
  input  logic [lcdfb_pkg::OP_W-1:0]     op_i,
  input  logic                          side_i,
  input  logic [lcdfb_pkg::PAGE_W-1:0]   page_i,
  input  logic [lcdfb_pkg::COL_IN_W-1:0] column_i,
  input  logic [lcdfb_pkg::BYTE_W-1:0]   data_byte_i,
  input  logic [lcdfb_pkg::ROW_W-1:0]    row_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [lcdfb_pkg::BYTE_W-1:0]   pixel_byte_o,
  output logic [lcdfb_pkg::IDX_W-1:0]    byte_index_o,
  output logic                          last_o
);
  import lcdfb_pkg::*;

  localparam int TOTAL_COLUMNS = 2 * COLUMNS_PER_SIDE;
  localparam int ROW_BYTES     = (TOTAL_COLUMNS + 7) / 8;
  localparam int GW            = $clog2(ROW_BYTES);
  localparam int XW            = GW + 3;
  localparam int CW            = $clog2(COLUMNS_PER_SIDE + 1);
  localparam int AW            = PAGE_W + GW;
  localparam int DEPTH         = 1 << AW;
  localparam int WORD_W        = LANES * BYTE_W;

  typedef struct packed {
    logic              last;
    logic [IDX_W-1:0]  idx;
    logic [BYTE_W-1:0] pixel;
  } out_entry_t;

  // Cursor
  logic              cur_side_q, cur_side_d;
  logic [PAGE_W-1:0] cur_page_q, cur_page_d;
  logic [CW-1:0]     cur_col_q, cur_col_d;

  // Memory: one word holds eight neighboring columns of one page
  logic [WORD_W-1:0] mem_q [DEPTH];
  logic [WORD_W-1:0] rdata_q;
  logic              mem_we;
  logic [LANES-1:0]  lane_we;
  logic [AW-1:0]     waddr;
  logic [BYTE_W-1:0] wdata;
  logic [AW-1:0]     raddr;
  logic [XW-1:0]     wr_x;

  logic [AW-1:0]     clr_cnt_q;
  logic [IDX_W-1:0]  rd_idx_q;
  logic [ROW_W-1:0]  row_q;

  logic              rv_q;
  logic [IDX_W-1:0]  rv_idx_q;
  logic              rv_last_q;
  logic [2:0]        rv_bit_q;
  logic [BYTE_W-1:0] pix;

  out_entry_t        fifo_q [2];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        cnt_q;
  logic              push, pop;
  logic [2:0]        occ;
  logic              wr_ok;

  assign wr_ok = (32'(cur_col_q) < COLUMNS_PER_SIDE);
  assign wr_x  = XW'(cur_col_q) + (cur_side_q ? XW'(COLUMNS_PER_SIDE) : XW'(0));

  always_comb begin
    cur_side_d = cur_side_q;
    cur_page_d = cur_page_q;
    cur_col_d  = cur_col_q;
    mem_we     = 1'b0;
    lane_we    = '0;
    waddr      = {cur_page_q, wr_x[XW-1:3]};
    wdata      = data_byte_i;
    if (cmd_i.clear_step) begin
      mem_we  = 1'b1;
      lane_we = '1;
      waddr   = clr_cnt_q;
      wdata   = '0;
    end else if (cmd_i.accept) begin
      case (op_e'(op_i))
        OP_LOCATE: begin
          cur_side_d = side_i;
          if (32'(page_i) < PAGES) begin
            cur_page_d = page_i;
          end
          if (32'(column_i) < COLUMNS_PER_SIDE) begin
            cur_col_d = CW'(column_i);
          end
        end
        OP_WRITE: begin
          if (wr_ok) begin
            mem_we             = 1'b1;
            lane_we[wr_x[2:0]] = 1'b1;
            cur_col_d          = cur_col_q + CW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_side_q <= 1'b0;
      cur_page_q <= '0;
      cur_col_q  <= '0;
      clr_cnt_q  <= '0;
      rd_idx_q   <= '0;
      rv_q       <= 1'b0;
    end else begin
      cur_side_q <= cur_side_d;
      cur_page_q <= cur_page_d;
      cur_col_q  <= cur_col_d;
      if (cmd_i.clear_step) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
      end
      if (cmd_i.read_start) begin
        rd_idx_q <= '0;
      end else if (cmd_i.read_issue) begin
        rd_idx_q <= rd_idx_q + IDX_W'(1);
      end
      rv_q <= cmd_i.read_issue;
    end
  end

  assign raddr = {row_q[ROW_W-1:3], rd_idx_q[GW-1:0]};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      for (int l = 0; l < LANES; l++) begin
        if (lane_we[l]) begin
          mem_q[waddr][l*BYTE_W +: BYTE_W] <= wdata;
        end
      end
    end
    if (cmd_i.read_issue) begin
      rdata_q   <= mem_q[raddr];
      rv_idx_q  <= rd_idx_q;
      rv_last_q <= (rd_idx_q == IDX_W'(ROW_BYTES - 1));
      rv_bit_q  <= row_q[2:0];
    end
    if (cmd_i.read_start) begin
      row_q <= row_i;
    end
  end

  // Pick the requested row bit out of each column byte
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      pix[k] = rdata_q[k*BYTE_W + 32'(rv_bit_q)];
    end
  end

  // Two-entry output queue
  assign push = rv_q;
  assign pop  = out_valid_o && out_ready_i;
  assign occ  = {1'b0, cnt_q} + {2'b00, rv_q} - {2'b00, pop};

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= '{last: rv_last_q, idx: rv_idx_q, pixel: pix};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  assign out_valid_o  = (cnt_q != 2'd0);
  assign pixel_byte_o = fifo_q[rd_ptr_q].pixel;
  assign byte_index_o = fifo_q[rd_ptr_q].idx;
  assign last_o       = fifo_q[rd_ptr_q].last;

  assign status_o.clear_done = (clr_cnt_q == '1);
  assign status_o.read_last  = (rd_idx_q == IDX_W'(ROW_BYTES - 1));
  assign status_o.out_space  = (occ < 3'd2);

endmodule

@@ sv/paged_lcd_frame_buffer_core.sv @@
// Frame buffer of a two-half graphic LCD, 2*COLUMNS_PER_SIDE columns by
// PAGES*8 rows (122x32 by default), stored as one byte per column and page.
// Input stream (s_axis): one command per transfer. Locate sets the cursor
// side, page and column; write stores a byte at the cursor and advances the
// column; read-row returns one pixel row on the output stream.
// Output stream (m_axis): ROW_BYTES transfers per read-row (16 by default),
// eight pixels each, bit 0 leftmost; tlast marks the final byte of the row.
// Locate and write produce no output and leave the input ready for the next
// command. Read-row keeps the input busy while it issues one word read per
// output byte, since the memory holds eight columns of one page per word on a
// single read port. The first byte passes the read data register and the
// output queue before it is valid.
// s_axis_tready stays low until the last word read of a row has been issued.
// After reset the memory is cleared one word per cycle, 4 << clog2(ROW_BYTES)
// words in all (64 by default), while s_axis_tready stays low.
// When the receiver stalls, a two-entry output queue holds finished bytes and
// word reads pause until there is room; nothing is lost or repeated.
module paged_lcd_frame_buffer_core #(
  parameter int COLUMNS_PER_SIDE = 61,
  parameter int PAGES            = 4
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // op[1:0], side[2], page[4:3], column[10:5], data_byte[18:11], row[23:19]
  input  logic [lcdfb_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // pixel_byte[7:0], byte_index[11:8], zero[15:12]
  output logic [lcdfb_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  output logic                                 m_axis_tlast_o
);
  import lcdfb_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  logic [OP_W-1:0]     in_op;
  logic                in_side;
  logic [PAGE_W-1:0]   in_page;
  logic [COL_IN_W-1:0] in_column;
  logic [BYTE_W-1:0]   in_data_byte;
  logic [ROW_W-1:0]    in_row;
  logic [BYTE_W-1:0]   pixel_byte;
  logic [IDX_W-1:0]    byte_index;

  // Unpack the command fields
  assign in_op        = s_axis_tdata_i[1:0];
  assign in_side      = s_axis_tdata_i[2];
  assign in_page      = s_axis_tdata_i[4:3];
  assign in_column    = s_axis_tdata_i[10:5];
  assign in_data_byte = s_axis_tdata_i[18:11];
  assign in_row       = s_axis_tdata_i[23:19];

  lcdfb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_op_i    (in_op),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lcdfb_dp #(
    .COLUMNS_PER_SIDE (COLUMNS_PER_SIDE),
    .PAGES            (PAGES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .op_i         (in_op),
    .side_i       (in_side),
    .page_i       (in_page),
    .column_i     (in_column),
    .data_byte_i  (in_data_byte),
    .row_i        (in_row),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .pixel_byte_o (pixel_byte),
    .byte_index_o (byte_index),
    .last_o       (m_axis_tlast_o)
  );

  // Pack the result: pixels low, index above, zero fill to the byte boundary
  assign m_axis_tdata_o = {(OUT_TDATA_W - BYTE_W - IDX_W)'(0), byte_index, pixel_byte};

endmodule

@@ verif/tb.sv @@
module tb;
  import lcdfb_pkg::*;

  // Geometry of the default build
  localparam int COLS_PER_SIDE = 61;
  localparam int N_PAGES       = 4;
  localparam int TOTAL_COLS    = 2 * COLS_PER_SIDE;
  localparam int ROW_BYTES     = (TOTAL_COLS + 7) / 8;
  localparam int N_CMDS        = 260;

  // Op code the block must ignore (not part of op_e)
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // One command; packed so that op lands in the lowest bits of tdata
  typedef struct packed {
    logic [ROW_W-1:0]    row;
    logic [BYTE_W-1:0]   data_byte;
    logic [COL_IN_W-1:0] column;
    logic [PAGE_W-1:0]   page;
    logic                side;
    logic [OP_W-1:0]     op;
  } lcd_cmd_t;

  // One packed output byte of a pixel row
  typedef struct packed {
    logic [BYTE_W-1:0] pixel_byte;
    logic [IDX_W-1:0]  byte_index;
    logic              last;
  } row_byte_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_valid = 1'b0;
  logic [IN_TDATA_W-1:0]  s_data = '0;
  logic                   s_axis_tready_o;
  logic                   m_axis_tvalid_o;
  logic                   m_ready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic                   m_axis_tlast_o;

  // Shadow of the frame buffer and its cursor
  logic [BYTE_W-1:0]   lcd_mem [0:TOTAL_COLS*N_PAGES-1];
  logic                cur_side;
  logic [PAGE_W-1:0]   cur_page;
  logic [COL_IN_W-1:0] cur_col;

  lcd_cmd_t  pending [$];
  row_byte_t row_bytes_due [$];
  lcd_cmd_t  cur_cmd;
  row_byte_t want;

  int  src_gap = 0;
  int  sink_stall = 0;
  bit  src_calm = 1'b0;
  bit  sink_calm = 1'b0;
  int  n_fail = 0;
  int  n_checked = 0;
  int  n_queued = 0;
  int  n_by_op [4] = '{0, 0, 0, 0};

  always #5 clk_i = ~clk_i;

  paged_lcd_frame_buffer_core #(
    .COLUMNS_PER_SIDE(COLS_PER_SIDE),
    .PAGES           (N_PAGES)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_data),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  // Update the shadow frame buffer for one accepted command and queue the
  // bytes a row read must return.
  task automatic apply_command(lcd_cmd_t c);
    logic [BYTE_W-1:0] acc;
    int x;
    row_byte_t rb;
    case (c.op)
      OP_LOCATE: begin
        cur_side = c.side;
        if (c.page < N_PAGES) cur_page = c.page;
        // Keep the old column when the new one is off the half
        if (c.column < COLS_PER_SIDE) cur_col = c.column;
      end
      OP_WRITE: begin
        // Drop the byte once the column has run past the half
        if (cur_col < COLS_PER_SIDE) begin
          lcd_mem[(cur_col + COLS_PER_SIDE * cur_side) * N_PAGES + cur_page] = c.data_byte;
          cur_col = cur_col + 1'b1;
        end
      end
      OP_READ_ROW: begin
        for (int b = 0; b < ROW_BYTES; b++) begin
          acc = '0;
          for (int k = 0; k < 8; k++) begin
            x = b * 8 + k;
            // Pixels right of the last column and rows below the panel read 0
            if (x < TOTAL_COLS && c.row < N_PAGES * 8)
              acc[k] = lcd_mem[x * N_PAGES + c.row / 8][c.row % 8];
          end
          rb.pixel_byte = acc;
          rb.byte_index = b[IDX_W-1:0];
          rb.last       = (b == ROW_BYTES - 1);
          row_bytes_due.push_back(rb);
        end
      end
      default: ;
    endcase
  endtask

  // Mostly short gaps, a few long ones, none while calm
  function automatic int idle_len(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  // Random content in every field, op fixed
  function automatic lcd_cmd_t rnd_cmd(logic [OP_W-1:0] op);
    logic [31:0] r;
    lcd_cmd_t c;
    r = $urandom;
    c = r[IN_W-1:0];
    c.op = op;
    return c;
  endfunction

  task automatic push_cmd(lcd_cmd_t c);
    pending.push_back(c);
    n_queued++;
  endtask

  task automatic push_fields(logic [OP_W-1:0] op, logic side, logic [PAGE_W-1:0] page,
                             logic [COL_IN_W-1:0] column, logic [BYTE_W-1:0] data_byte,
                             logic [ROW_W-1:0] row);
    lcd_cmd_t c;
    c = '{row: row, data_byte: data_byte, column: column, page: page, side: side, op: op};
    push_cmd(c);
  endtask

  // Driver: present the next pending command, hold it until the transfer,
  // then idle for a random gap before the next one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
      s_data  <= '0;
      src_gap <= 0;
    end else begin
      if (s_valid && s_axis_tready_o) begin
        apply_command(cur_cmd);
        n_by_op[cur_cmd.op]++;
      end
      if (!s_valid || s_axis_tready_o) begin
        if (src_gap != 0) begin
          src_gap <= src_gap - 1;
          s_valid <= 1'b0;
        end else if (pending.size() != 0) begin
          cur_cmd = pending.pop_front();
          s_data  <= cur_cmd;
          s_valid <= 1'b1;
          if ($urandom_range(24) == 0) src_calm = !src_calm;
          src_gap <= idle_len(src_calm);
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare every output transfer with the oldest expected byte,
  // and stall the output at random cycles.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_ready    <= 1'b0;
      sink_stall <= 0;
    end else begin
      if (m_ready && m_axis_tvalid_o) begin
        if (row_bytes_due.size() == 0) begin
          $error("output byte %0h with no row read outstanding", m_axis_tdata_o[7:0]);
          n_fail++;
        end else begin
          want = row_bytes_due.pop_front();
          n_checked++;
          if (m_axis_tdata_o[7:0] !== want.pixel_byte) begin
            $error("pixel_byte: expected %0h, got %0h", want.pixel_byte,
                   m_axis_tdata_o[7:0]);
            n_fail++;
          end
          if (m_axis_tdata_o[11:8] !== want.byte_index) begin
            $error("byte_index: expected %0d, got %0d", want.byte_index,
                   m_axis_tdata_o[11:8]);
            n_fail++;
          end
          if (m_axis_tlast_o !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, m_axis_tlast_o);
            n_fail++;
          end
        end
      end
      if (sink_stall != 0) begin
        sink_stall <= sink_stall - 1;
        m_ready    <= 1'b0;
      end else begin
        m_ready <= 1'b1;
        if ($urandom_range(59) == 0) sink_calm = !sink_calm;
        if ($urandom_range(5) == 0) sink_stall <= idle_len(sink_calm);
      end
    end
  end

  initial begin
    lcd_cmd_t c;
    int kind;
    int n_wr;
    foreach (lcd_mem[i]) lcd_mem[i] = '0;
    cur_side = 1'b0;
    cur_page = '0;
    cur_col  = '0;

    // Directed: cleared memory, both halves, edge columns, write past the end,
    // ignored locate column, unused op, first and last rows.
    push_fields(OP_READ_ROW, 1'b0, 2'd0, 6'd0,  8'h00, 5'd0);
    push_fields(OP_LOCATE,   1'b0, 2'd0, 6'd0,  8'h00, 5'd0);
    push_fields(OP_WRITE,    1'b0, 2'd0, 6'd0,  8'hFF, 5'd0);
    push_fields(OP_WRITE,    1'b0, 2'd0, 6'd0,  8'hA5, 5'd0);
    push_fields(OP_LOCATE,   1'b1, 2'd3, 6'd60, 8'h00, 5'd0);
    push_fields(OP_WRITE,    1'b1, 2'd3, 6'd60, 8'h80, 5'd31);
    push_fields(OP_WRITE,    1'b0, 2'd0, 6'd0,  8'h7F, 5'd0);
    push_fields(OP_LOCATE,   1'b0, 2'd2, 6'd63, 8'hFF, 5'd31);
    push_fields(OP_WRITE,    1'b1, 2'd3, 6'd63, 8'h55, 5'd31);
    push_fields(OP_LOCATE,   1'b1, 2'd1, 6'd61, 8'h00, 5'd0);
    push_fields(OP_LOCATE,   1'b0, 2'd1, 6'd5,  8'h00, 5'd0);
    push_fields(OP_WRITE,    1'b0, 2'd0, 6'd0,  8'h3C, 5'd0);
    push_fields(OP_UNUSED,   1'b1, 2'd3, 6'd63, 8'hFF, 5'd31);
    push_fields(OP_READ_ROW, 1'b0, 2'd0, 6'd0,  8'h00, 5'd31);
    push_fields(OP_READ_ROW, 1'b1, 2'd3, 6'd63, 8'hFF, 5'd0);
    push_fields(OP_READ_ROW, 1'b0, 2'd0, 6'd0,  8'h00, 5'd10);
    push_fields(OP_LOCATE,   1'b1, 2'd0, 6'd0,  8'h00, 5'd0);
    push_fields(OP_WRITE,    1'b0, 2'd0, 6'd0,  8'h01, 5'd0);
    push_fields(OP_WRITE,    1'b0, 2'd0, 6'd0,  8'hFF, 5'd0);
    push_fields(OP_READ_ROW, 1'b0, 2'd0, 6'd0,  8'h00, 5'd0);
    push_fields(OP_READ_ROW, 1'b0, 2'd0, 6'd0,  8'h00, 5'd5);
    push_fields(OP_READ_ROW, 1'b0, 2'd0, 6'd0,  8'h00, 5'd15);

    // Random: mostly locate followed by a run of writes, row reads in
    // between, a little noise from stray writes and the unused op.
    while (n_queued < N_CMDS) begin
      kind = $urandom_range(19);
      if (kind < 10) begin
        c = rnd_cmd(OP_LOCATE);
        n_wr = $urandom_range(8, 1);
        if ($urandom_range(7) == 0) begin
          // Start near the end of the half so the run can spill past it
          c.column = $urandom_range(60, 54);
          n_wr = $urandom_range(12, 4);
        end else if ($urandom_range(7) != 0) begin
          c.column = $urandom_range(COLS_PER_SIDE - 1);
        end
        push_cmd(c);
        repeat (n_wr) push_cmd(rnd_cmd(OP_WRITE));
      end else if (kind < 17) begin
        push_cmd(rnd_cmd(OP_READ_ROW));
      end else if (kind == 17) begin
        push_cmd(rnd_cmd(OP_UNUSED));
      end else begin
        push_cmd(rnd_cmd(OP_WRITE));
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain: every command taken, every row byte seen, then a quiet tail
    while (pending.size() != 0 || s_valid) @(posedge clk_i);
    while (row_bytes_due.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("Ran %0d commands: %0d locate, %0d write, %0d row read, %0d unused op.",
             n_queued, n_by_op[OP_LOCATE], n_by_op[OP_WRITE], n_by_op[OP_READ_ROW],
             n_by_op[OP_UNUSED]);
    $display("Compared %0d row bytes with the shadow frame buffer, %0d mismatches.",
             n_checked, n_fail);
    if (n_fail == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #10000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
